### rtl/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the scoped symbol table
// Holds the request and response formats, the request codes, the status
// codes, the stored entry layout and the controller state encoding.
// ----------------------------------------------------------------------------
package sst_pkg;

	// Default number of table entries.
	localparam int unsigned TABLE_DEPTH_DEF = 16;

	// Field widths fixed by the request and response formats.
	localparam int unsigned OP_W     = 3;
	localparam int unsigned KEY_W    = 64;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned USED_W   = 5;

	// Request codes.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_LOOKUP = 3'd1,
		OP_UPDATE = 3'd2,
		OP_DELETE = 3'd3,
		OP_PURGE  = 3'd4
	} op_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// One stored table entry.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] scope;
	} entry_t;

	// One request as seen by the controller.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] scope_tag;
	} req_t;

	// One response as produced by the controller.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   found_value;
		logic [BYTE_W-1:0]   found_scope;
		logic [USED_W-1:0]   entries_used;
	} res_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

### rtl/sst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/sst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_ctrl: request sequencer of the scoped symbol table
// Takes one request at a time, walks the entry memory with a read and a
// check state per entry, rewrites or compacts entries in place, and hands
// a response to the output register.
// ----------------------------------------------------------------------------
module sst_ctrl #(
	parameter int unsigned TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire sst_pkg::req_t                  req,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output sst_pkg::res_t                       res,
	output logic                                mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]      mem_waddr,
	output sst_pkg::entry_t                     mem_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]      mem_raddr,
	input  wire sst_pkg::entry_t                mem_rdata
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	sst_pkg::state_t              state_q, state_nx;
	sst_pkg::op_t                 op_q;
	logic [sst_pkg::KEY_W-1:0]    key_q;
	logic [sst_pkg::BYTE_W-1:0]   data_q;
	logic [sst_pkg::BYTE_W-1:0]   scope_q;
	logic [IW-1:0]                idx_q;
	logic [CW-1:0]                kept_q;
	logic [CW-1:0]                count_q;
	sst_pkg::status_t             status_q;
	logic [sst_pkg::BYTE_W-1:0]   fv_q;
	logic [sst_pkg::BYTE_W-1:0]   fs_q;

	sst_pkg::op_t                 req_op;
	logic                         accept;
	logic                         full;
	logic                         scan_op;
	logic                         name_hit;
	logic                         scope_hit;
	logic                         drop_hit;
	logic                         scan_last;
	logic                         scan_stop;
	logic [CW-1:0]                kept_nx;

	assign req_op = sst_pkg::op_t'(req.op);
	assign accept = req_valid && req_ready;
	assign full   = (count_q == CW'(TABLE_DEPTH));

	// Decode of the entry under check.
	always_comb begin
		scan_op   = (req_op == sst_pkg::OP_LOOKUP) || (req_op == sst_pkg::OP_UPDATE) ||
		            (req_op == sst_pkg::OP_DELETE) || (req_op == sst_pkg::OP_PURGE);
		name_hit  = (mem_rdata.key == key_q);
		scope_hit = (mem_rdata.scope == scope_q);
		drop_hit  = (op_q == sst_pkg::OP_PURGE) ? scope_hit : name_hit;
		kept_nx   = kept_q + CW'(!drop_hit);
		scan_last = ((CW'(idx_q) + CW'(1)) == count_q);
		scan_stop = scan_last ||
		            (((op_q == sst_pkg::OP_LOOKUP) || (op_q == sst_pkg::OP_UPDATE)) && name_hit);
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sst_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nx = (scan_op && (count_q != '0)) ? sst_pkg::S_READ : sst_pkg::S_FINISH;
				end
			end
			sst_pkg::S_READ: begin
				state_nx = sst_pkg::S_CHECK;
			end
			sst_pkg::S_CHECK: begin
				state_nx = scan_stop ? sst_pkg::S_FINISH : sst_pkg::S_READ;
			end
			sst_pkg::S_FINISH: begin
				if (res_ready) begin
					state_nx = sst_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = sst_pkg::S_IDLE;
			end
		endcase
	end

	// Handshake and memory port outputs.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		unique case (state_q)
			sst_pkg::S_IDLE: begin
				req_ready = 1'b1;
				// Insert appends at the current end of the table.
				if (req_valid && (req_op == sst_pkg::OP_INSERT) && !full) begin
					mem_we          = 1'b1;
					mem_waddr       = count_q[IW-1:0];
					mem_wdata.key   = req.key;
					mem_wdata.value = req.data_byte;
					mem_wdata.scope = req.scope_tag;
				end
			end
			sst_pkg::S_READ: begin
			end
			sst_pkg::S_CHECK: begin
				if (op_q == sst_pkg::OP_UPDATE) begin
					mem_we          = name_hit;
					mem_wdata.value = data_q;
				end else if ((op_q == sst_pkg::OP_DELETE) || (op_q == sst_pkg::OP_PURGE)) begin
					// Kept entries move down to the compacted position.
					mem_we    = !drop_hit;
					mem_waddr = kept_q[IW-1:0];
				end
			end
			sst_pkg::S_FINISH: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.status       = status_q;
	assign res.found_value  = fv_q;
	assign res.found_scope  = fs_q;
	assign res.entries_used = sst_pkg::USED_W'(count_q);

	// Request payload, capture on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req_op;
			key_q   <= req.key;
			data_q  <= req.data_byte;
			scope_q <= req.scope_tag;
		end
	end

	// Control state and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sst_pkg::S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			kept_q   <= '0;
			status_q <= sst_pkg::ST_OK;
			fv_q     <= '0;
			fs_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				idx_q    <= '0;
				kept_q   <= '0;
				fv_q     <= '0;
				fs_q     <= '0;
				status_q <= sst_pkg::ST_OK;
				if (req_op == sst_pkg::OP_INSERT) begin
					if (full) begin
						status_q <= sst_pkg::ST_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end else if ((count_q == '0) && ((req_op == sst_pkg::OP_LOOKUP) ||
				             (req_op == sst_pkg::OP_UPDATE) || (req_op == sst_pkg::OP_DELETE))) begin
					status_q <= sst_pkg::ST_NOTFOUND;
				end
			end
			if (state_q == sst_pkg::S_CHECK) begin
				idx_q  <= idx_q + IW'(1);
				kept_q <= kept_nx;
				if ((op_q == sst_pkg::OP_LOOKUP) || (op_q == sst_pkg::OP_UPDATE)) begin
					if (name_hit) begin
						if (op_q == sst_pkg::OP_LOOKUP) begin
							fv_q <= mem_rdata.value;
							fs_q <= mem_rdata.scope;
						end
					end else if (scan_last) begin
						status_q <= sst_pkg::ST_NOTFOUND;
					end
				end else if (scan_last) begin
					count_q <= kept_nx;
					if ((op_q == sst_pkg::OP_DELETE) && (kept_nx == count_q)) begin
						status_q <= sst_pkg::ST_NOTFOUND;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table size");

	// Compaction never writes ahead of the entry being checked.
	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::S_CHECK) |-> (kept_q <= CW'(idx_q)))
		else $error("compaction pointer ahead of scan pointer");

	// Memory writes stay inside the used part of the table or append at its end.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("memory write beyond table end");

	// A successful insert grows the table by one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_op == sst_pkg::OP_INSERT) && !full) |=>
		(count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");
`endif

endmodule
`default_nettype wire

### rtl/scoped_symbol_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert and unknown requests, and any request while the table is empty, go from S_IDLE
// straight to S_FINISH; lookup, update, delete and purge otherwise pass through S_READ
// and S_CHECK for each entry examined. One request is handled at a time, as each entry
// is read and then checked through the single entry memory port.
// A new request is taken while the previous response waits in the output register.
// Reset clears the entry count and the handshake state; entry memory is not cleared.
// ----------------------------------------------------------------------------
// scoped_symbol_table: ordered table of named byte variables with scopes
// Supports insert, lookup, update, delete by name and purge by scope over
// a single entry memory with in-place compaction.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
	parameter int unsigned TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // key[63:0], data_byte[71:64], scope_tag[79:72]
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // status[1:0], found_value[9:2], found_scope[17:10],
	                                   // entries_used[22:18], zero[23]
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);

	sst_pkg::req_t   req;
	sst_pkg::res_t   res;
	logic            res_valid;
	logic            res_ready;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	sst_pkg::entry_t mem_wdata;
	logic [IW-1:0]   mem_raddr;
	sst_pkg::entry_t mem_rdata;
	sst_pkg::res_t   out_q;
	logic            out_valid_q;

	// Unpack the incoming request.
	assign req.op        = s_tuser;
	assign req.key       = s_tdata[63:0];
	assign req.data_byte = s_tdata[71:64];
	assign req.scope_tag = s_tdata[79:72];

	sst_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sst_ram #(
		.WIDTH ($bits(sst_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: loads when empty or when its response is taken.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.entries_used, out_q.found_scope,
	                   out_q.found_value, out_q.status};

endmodule
`default_nettype wire
